// File: hw/rtl/crc8fr_pkg.sv
`default_nettype none

package crc8fr_pkg;

  localparam int unsigned MaxFrame = 64;
  localparam int unsigned MinFrame = 4;

  localparam logic [1:0] FUNC_BYTE    = 2'd0;
  localparam logic [1:0] FUNC_SEL_ON  = 2'd1;
  localparam logic [1:0] FUNC_SEL_OFF = 2'd2;

  localparam logic [1:0] REG_START_BYTE    = 2'd0;
  localparam logic [1:0] REG_CRC_POLY      = 2'd1;
  localparam logic [1:0] REG_CRC_REFLECTED = 2'd2;

  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_CRC_ERR = 2'd1;
  localparam logic [1:0] STATUS_BAD_LEN = 2'd2;

  localparam logic       KIND_BODY      = 1'b0;
  localparam logic       KIND_FRAME_END = 1'b1;

  localparam logic [7:0] START_BYTE_RST    = 8'h2a;
  localparam logic [7:0] CRC_POLY_RST      = 8'h31;
  localparam logic       CRC_REFLECTED_RST = 1'b1;

  typedef enum logic [3:0] {
    MODE_INACTIVE = 4'b0001,
    MODE_LISTEN   = 4'b0010,
    MODE_RECEIVE  = 4'b0100,
    MODE_RESPOND  = 4'b1000
  } link_mode_e;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_beat_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] data_byte;
    logic [7:0] type_byte;
    logic [7:0] length_byte;
    logic [1:0] status;
  } out_beat_t;

  function automatic logic [7:0] bit_rev8(input logic [7:0] v);
    logic [7:0] r;
    for (int i = 0; i < 8; i++) begin
      r[i] = v[7 - i];
    end
    return r;
  endfunction

  function automatic logic [7:0] crc8_next(input logic [7:0] crc_in,
                                           input logic [7:0] b,
                                           input logic [7:0] poly,
                                           input logic       reflected);
    logic [7:0] c;
    logic [7:0] rp;
    c  = crc_in ^ b;
    rp = bit_rev8(poly);
    for (int i = 0; i < 8; i++) begin
      if (reflected) begin
        c = c[0] ? ((c >> 1) ^ rp) : (c >> 1);
      end else begin
        c = c[7] ? ((c << 1) ^ poly) : (c << 1);
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/crc8_frame_receiver_top.sv
// a result beat is registered on the output in the cycle after its input beat is accepted
// throughput: one input beat per cycle; input is held only while a result waits unread
// the per-byte crc8 update and frame counter logic sit combinationally before the output register
// reset: asynchronous active low, link inactive, counters zero, registers at defaults
`default_nettype none

module crc8_frame_receiver_top (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire crc8fr_pkg::in_beat_t  in_data_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output crc8fr_pkg::out_beat_t      out_data_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [1:0]            cfg_index_i,
  input  wire logic [7:0]            cfg_wdata_i
);
  import crc8fr_pkg::*;

  logic [7:0] start_byte_q;
  logic [7:0] crc_poly_q;
  logic       crc_reflected_q;

  link_mode_e mode_q, mode_d;
  logic [7:0] byte_index_q, byte_index_d;
  logic [7:0] exp_len_q, exp_len_d;
  logic [7:0] type_q, type_d;
  logic [7:0] crc_q, crc_d;

  logic       out_valid_q;
  out_beat_t  out_data_q;

  logic       in_fire;
  logic       res_valid;
  out_beat_t  res;
  logic [7:0] crc_upd;
  logic [7:0] b;
  logic [8:0] pos_next;

  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  assign b        = in_data_i.rx_byte;
  assign crc_upd  = crc8_next(crc_q, b, crc_poly_q, crc_reflected_q);
  assign pos_next = {1'b0, byte_index_q} + 9'd1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q    <= START_BYTE_RST;
      crc_poly_q      <= CRC_POLY_RST;
      crc_reflected_q <= CRC_REFLECTED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_START_BYTE:    start_byte_q    <= cfg_wdata_i;
        REG_CRC_POLY:      crc_poly_q      <= cfg_wdata_i;
        REG_CRC_REFLECTED: crc_reflected_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    mode_d       = mode_q;
    byte_index_d = byte_index_q;
    exp_len_d    = exp_len_q;
    type_d       = type_q;
    crc_d        = crc_q;
    res_valid    = 1'b0;
    res          = '0;
    if (in_fire) begin
      unique case (in_data_i.func) inside
        FUNC_SEL_ON, FUNC_SEL_OFF: begin
          mode_d       = (in_data_i.func == FUNC_SEL_ON) ? MODE_LISTEN : MODE_INACTIVE;
          byte_index_d = '0;
          exp_len_d    = '0;
          type_d       = '0;
          crc_d        = '0;
        end
        FUNC_BYTE: begin
          unique case (mode_q)
            MODE_LISTEN: begin
              if (b == start_byte_q) begin
                exp_len_d    = '0;
                type_d       = '0;
                crc_d        = crc8_next(8'd0, b, crc_poly_q, crc_reflected_q);
                byte_index_d = 8'd1;
                mode_d       = MODE_RECEIVE;
              end
            end
            MODE_RECEIVE: begin
              crc_d = crc_upd;
              if (byte_index_q <= 8'd1) begin
                type_d       = b;
                byte_index_d = 8'd2;
              end else if (byte_index_q == 8'd2) begin
                exp_len_d = b;
                if (b < 8'(MinFrame) || b > 8'(MaxFrame)) begin
                  res_valid       = 1'b1;
                  res.kind        = KIND_FRAME_END;
                  res.type_byte   = type_q;
                  res.length_byte = b;
                  res.status      = STATUS_BAD_LEN;
                  mode_d          = MODE_LISTEN;
                  byte_index_d    = '0;
                  exp_len_d       = '0;
                  type_d          = '0;
                  crc_d           = '0;
                end else begin
                  byte_index_d = 8'd3;
                end
              end else if (pos_next >= {1'b0, exp_len_q}) begin
                res_valid       = 1'b1;
                res.kind        = KIND_FRAME_END;
                res.type_byte   = type_q;
                res.length_byte = exp_len_q;
                res.status      = (crc_upd != 8'd0) ? STATUS_CRC_ERR : STATUS_OK;
                mode_d          = (crc_upd != 8'd0) ? MODE_LISTEN : MODE_RESPOND;
                byte_index_d    = '0;
                exp_len_d       = '0;
                type_d          = '0;
                crc_d           = '0;
              end else begin
                res_valid     = 1'b1;
                res.kind      = KIND_BODY;
                res.data_byte = b;
                byte_index_d  = pos_next[7:0];
              end
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_INACTIVE;
      byte_index_q <= '0;
      exp_len_q    <= '0;
      type_q       <= '0;
      crc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      mode_q       <= mode_d;
      byte_index_q <= byte_index_d;
      exp_len_q    <= exp_len_d;
      type_q       <= type_d;
      crc_q        <= crc_d;
      if (in_fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_fire && res_valid) begin
      out_data_q <= res;
    end
  end

endmodule

`default_nettype wire

// File: bench/crc8_frame_receiver_top_tb.sv
`timescale 1ns / 1ps

module crc8_frame_receiver_top_tb;
  import crc8fr_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           in_valid_i;
  logic           in_ready_o;
  in_beat_t       in_data_i;
  logic           out_valid_o;
  logic           out_ready_i;
  out_beat_t      out_data_o;
  logic           cfg_we_i;
  logic [1:0]     cfg_index_i;
  logic [7:0]     cfg_wdata_i;

  bit             steady = 1'b0;
  int             beats_sent = 0;
  int             mismatch_count = 0;

  logic [7:0]     cfg_start_q = START_BYTE_RST;
  logic [7:0]     cfg_poly_q = CRC_POLY_RST;
  logic           cfg_refl_q = CRC_REFLECTED_RST;
  link_mode_e     link_q = MODE_INACTIVE;
  logic [7:0]     frame_pos_q = '0;
  logic [7:0]     frame_len_q = '0;
  logic [7:0]     type_byte_q = '0;
  logic [7:0]     frame_crc_q = '0;
  out_beat_t      deframed_beats[$];

  crc8_frame_receiver_top u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_ready_i <= steady || ($urandom_range(99) >= 27);
  end

  function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] b);
    logic [7:0] r;
    logic [7:0] taps;
    r = acc ^ b;
    for (int i = 0; i < 8; i++) begin
      taps[i] = cfg_poly_q[7 - i];
    end
    for (int k = 0; k < 8; k++) begin
      if (cfg_refl_q) begin
        r = {1'b0, r[7:1]} ^ (r[0] ? taps : 8'h00);
      end else begin
        r = {r[6:0], 1'b0} ^ (r[7] ? cfg_poly_q : 8'h00);
      end
    end
    return r;
  endfunction

  task automatic clear_frame();
    frame_pos_q = '0;
    frame_len_q = '0;
    type_byte_q = '0;
    frame_crc_q = '0;
  endtask

  task automatic deframe_step(input in_beat_t beat);
    out_beat_t  res;
    logic [7:0] pos;
    logic [7:0] b;
    res = '0;
    b = beat.rx_byte;
    case (beat.func)
      FUNC_SEL_ON: begin
        link_q = MODE_LISTEN;
        clear_frame();
      end
      FUNC_SEL_OFF: begin
        link_q = MODE_INACTIVE;
        clear_frame();
      end
      FUNC_BYTE: begin
        if (link_q == MODE_LISTEN) begin
          if (b == cfg_start_q) begin
            clear_frame();
            frame_crc_q = crc8_step(8'h00, b);
            frame_pos_q = 8'd1;
            link_q = MODE_RECEIVE;
          end
        end else if (link_q == MODE_RECEIVE) begin
          pos = frame_pos_q;
          frame_crc_q = crc8_step(frame_crc_q, b);
          if (pos <= 8'd1) begin
            type_byte_q = b;
            frame_pos_q = 8'd2;
          end else if (pos == 8'd2) begin
            frame_len_q = b;
            if (b < MinFrame || b > MaxFrame) begin
              res.kind = KIND_FRAME_END;
              res.type_byte = type_byte_q;
              res.length_byte = b;
              res.status = STATUS_BAD_LEN;
              deframed_beats.push_back(res);
              link_q = MODE_LISTEN;
              clear_frame();
            end else begin
              frame_pos_q = 8'd3;
            end
          end else if ({1'b0, pos} + 9'd1 >= {1'b0, frame_len_q}) begin
            res.kind = KIND_FRAME_END;
            res.type_byte = type_byte_q;
            res.length_byte = frame_len_q;
            res.status = (frame_crc_q != 8'h00) ? STATUS_CRC_ERR : STATUS_OK;
            deframed_beats.push_back(res);
            link_q = (res.status == STATUS_OK) ? MODE_RESPOND : MODE_LISTEN;
            clear_frame();
          end else begin
            res.kind = KIND_BODY;
            res.data_byte = b;
            deframed_beats.push_back(res);
            frame_pos_q = pos + 8'd1;
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(input out_beat_t got);
    out_beat_t want;
    if (deframed_beats.size() == 0) begin
      report_mismatch("unexpected result kind", got.kind, 0);
      return;
    end
    want = deframed_beats.pop_front();
    if (got.kind !== want.kind) report_mismatch("kind", got.kind, want.kind);
    if (got.data_byte !== want.data_byte) begin
      report_mismatch("data_byte", got.data_byte, want.data_byte);
    end
    if (got.type_byte !== want.type_byte) begin
      report_mismatch("type_byte", got.type_byte, want.type_byte);
    end
    if (got.length_byte !== want.length_byte) begin
      report_mismatch("length_byte", got.length_byte, want.length_byte);
    end
    if (got.status !== want.status) report_mismatch("status", got.status, want.status);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) deframe_step(in_data_i);
      if (out_valid_o && out_ready_i) check_result(out_data_o);
    end
  end

  // valid stays high after a beat until the next call decides on a gap
  task automatic send_beat(input logic [1:0] func, input logic [7:0] b);
    in_beat_t beat;
    beat.func = func;
    beat.rx_byte = b;
    if (!steady && $urandom_range(99) < 27) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 25);
    end
    in_valid_i <= 1'b1;
    in_data_i <= beat;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (deframed_beats.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic program_regs(input logic [7:0] sb, input logic [7:0] poly,
                              input logic refl);
    cfg_we_i <= 1'b1;
    cfg_index_i <= REG_START_BYTE;
    cfg_wdata_i <= sb;
    @(posedge clk_i);
    cfg_index_i <= REG_CRC_POLY;
    cfg_wdata_i <= poly;
    @(posedge clk_i);
    cfg_index_i <= REG_CRC_REFLECTED;
    cfg_wdata_i <= {7'd0, refl};
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_start_q = sb;
    cfg_poly_q = poly;
    cfg_refl_q = refl;
  endtask

  // sends up to cut bytes of a frame; crc byte closes the remainder unless corrupted
  task automatic send_frame(input logic [7:0] ftype, input int len, input int cut,
                            input bit bad_crc);
    logic [7:0] fcs;
    logic [7:0] b;
    int         total;
    int         k;
    total = (len < MinFrame || len > MaxFrame) ? 3 : len;
    fcs = 8'h00;
    for (k = 0; k < total && k < cut; k++) begin
      if (k == 0) b = cfg_start_q;
      else if (k == 1) b = ftype;
      else if (k == 2) b = len[7:0];
      else if (k == total - 1) b = fcs ^ (bad_crc ? 8'($urandom_range(255, 1)) : 8'h00);
      else b = 8'($urandom);
      fcs = crc8_step(fcs, b);
      send_beat(FUNC_BYTE, b);
    end
  endtask

  task automatic test_link_control();
    send_beat(FUNC_SEL_OFF, 8'h00);
    send_beat(FUNC_BYTE, 8'hff);
    send_beat(FUNC_UNUSED, 8'hff);
    send_beat(FUNC_SEL_ON, 8'h00);
    send_beat(FUNC_BYTE, 8'h00);
  endtask

  task automatic test_frame_outcomes();
    send_frame(8'hff, MinFrame, 255, 1'b0);
    send_beat(FUNC_BYTE, cfg_start_q);
    send_beat(FUNC_SEL_ON, 8'hff);
    send_frame(8'h00, 5, 255, 1'b1);
    send_frame(8'h5a, 3, 255, 1'b0);
    send_frame(8'ha5, MaxFrame + 1, 255, 1'b0);
    send_frame(8'h3c, 6, 3, 1'b0);
    send_beat(FUNC_SEL_ON, 8'h00);
  endtask

  task automatic test_random_frames(input int n, input logic [7:0] sb,
                                    input logic [7:0] poly, input logic refl,
                                    input bit no_idle);
    int stop_at;
    int r;
    int len;
    int cut;
    bit bad_crc;
    settle();
    program_regs(sb, poly, refl);
    steady = no_idle;
    stop_at = beats_sent + n;
    send_beat(FUNC_SEL_ON, 8'($urandom));
    while (beats_sent < stop_at) begin
      r = $urandom_range(99);
      if (r < 5) begin
        send_beat(FUNC_SEL_OFF, 8'($urandom));
        send_beat(FUNC_BYTE, 8'($urandom));
        send_beat(FUNC_SEL_ON, 8'($urandom));
      end else if (r < 8) begin
        send_beat(FUNC_UNUSED, 8'($urandom));
      end else if (r < 14) begin
        send_beat(FUNC_BYTE, 8'($urandom));
      end else begin
        r = $urandom_range(99);
        if (r < 8) begin
          case ($urandom_range(2))
            0: len = $urandom_range(MinFrame - 1, 0);
            1: len = MaxFrame + 1;
            default: len = $urandom_range(255, MaxFrame + 1);
          endcase
        end else if (r < 12) begin
          len = MaxFrame;
        end else if (r < 24) begin
          len = $urandom_range(MaxFrame, 13);
        end else begin
          len = $urandom_range(12, MinFrame);
        end
        cut = ($urandom_range(99) < 6) ? $urandom_range(len < MinFrame ? 2 : 3, 1) : 255;
        bad_crc = ($urandom_range(99) < 15);
        send_frame(8'($urandom), len, cut, bad_crc);
        if (cut < 255) begin
          send_beat($urandom_range(1) ? FUNC_SEL_ON : FUNC_SEL_OFF, 8'($urandom));
          send_beat(FUNC_SEL_ON, 8'($urandom));
        end else if (len >= MinFrame && len <= MaxFrame) begin
          if ($urandom_range(99) < 30) send_beat(FUNC_BYTE, 8'($urandom));
          send_beat(FUNC_SEL_ON, 8'($urandom));
        end
      end
    end
    settle();
    steady = 1'b0;
  endtask

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    out_ready_i = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_START_BYTE;
    cfg_wdata_i = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_link_control();
    test_frame_outcomes();
    test_random_frames(160, 8'h00, 8'h00, 1'b0, 1'b0);
    test_random_frames(160, 8'hff, 8'hff, 1'b1, 1'b0);
    test_random_frames(160, START_BYTE_RST, 8'h07, 1'b0, 1'b1);
    test_random_frames(160, 8'($urandom), 8'($urandom), 1'($urandom), 1'b0);
    test_random_frames(160, START_BYTE_RST, CRC_POLY_RST, CRC_REFLECTED_RST, 1'b0);
    settle();
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
